// ----- hw/rtl/lpd_pkg.sv -----
// lpd_pkg: shared types and constants of the length-prefixed deframer
// used by the channel interfaces, the register block, the parser and the top level
// no dependencies

package lpd_pkg;

	// configuration register layout
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int MAXP_W = 26;
	localparam int TOTAL_W = 27;

	// register indexes (byte address is four times the index)
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;
	localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

	// framing modes
	localparam logic [1:0] MODE_ABRIDGED = 2'd0;
	localparam logic [1:0] MODE_INTERMEDIATE = 2'd1;
	localparam logic [1:0] MODE_PADDED = 2'd2;

	// abridged escape bytes that announce a long header
	localparam logic [7:0] ESC_LO = 8'h7F;
	localparam logic [7:0] ESC_HI = 8'hFF;

	localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 26'd10485760;

	typedef struct packed {
		logic enable;
		logic [1:0] mode;
		logic [MAXP_W-1:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic is_header;
		logic frame_last;
		logic length_valid;
		logic [TOTAL_W-1:0] frame_total;
		logic length_error;
	} result_t;

endpackage

// ----- hw/rtl/lpd_if.sv -----
// lpd_in_if / lpd_out_if: valid/ready channels of the deframer
// the input carries one stream byte, the output one tagged byte
// depends on lpd_pkg

interface lpd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] byte_out;
	logic is_header;
	logic frame_last;
	logic length_valid;
	logic [TOTAL_W-1:0] frame_total;
	logic length_error;

	modport source (output valid, output byte_out, output is_header, output frame_last,
		output length_valid, output frame_total, output length_error, input ready);
	modport sink (input valid, input byte_out, input is_header, input frame_last,
		input length_valid, input frame_total, input length_error, output ready);
endinterface

// ----- hw/rtl/lpd_regs.sv -----
// lpd_regs: APB configuration registers of the deframer (enable, mode, max_payload)
// depends on lpd_pkg

module lpd_regs import lpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic wr_en;
	logic [1:0] reg_idx;
	cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg = cfg_q;

	// register writes, values masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.mode <= MODE_ABRIDGED;
			cfg_q.max_payload <= MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLE: cfg_q.enable <= pwdata[0];
				REG_MODE: cfg_q.mode <= pwdata[1:0];
				REG_MAX_PAYLOAD: cfg_q.max_payload <= pwdata[MAXP_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_q.enable};
			REG_MODE: prdata = {{(DATA_W-2){1'b0}}, cfg_q.mode};
			REG_MAX_PAYLOAD: prdata = {{(DATA_W-MAXP_W){1'b0}}, cfg_q.max_payload};
			default: prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/lpd_parse.sv -----
// lpd_parse: frame state, header accumulator and byte tagging of the deframer
// produces the result for the current byte and updates state on step while enabled
// depends on lpd_pkg

module lpd_parse import lpd_pkg::*; #(
	parameter int LEN_WIDTH = 27
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic step,
	input logic [7:0] data_byte,
	output result_t res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR = 2'd2
	} phase_t;

	phase_t phase_q;
	logic [1:0] hdr_cnt_q;
	logic hdr_long_q;
	logic [31:0] accum_q;
	logic [LEN_WIDTH-1:0] frame_len_q;
	logic [LEN_WIDTH-1:0] pos_q;

	logic long_hdr;
	logic hdr_done;
	logic bad_len;
	logic pos_last;
	logic [4:0] shamt;
	logic [31:0] accum_nx;
	logic [31:0] payload;
	logic [32:0] total_hdr;
	logic [32:0] flen_ext;
	logic [LEN_WIDTH-1:0] pos_inc;

	// header decode and payload counting
	always_comb begin
		shamt = {hdr_cnt_q, 3'b000};
		if (hdr_cnt_q == 2'd0) begin
			long_hdr = !(cfg.mode == MODE_ABRIDGED && data_byte != ESC_LO
				&& data_byte != ESC_HI);
		end else begin
			long_hdr = hdr_long_q;
		end
		accum_nx = accum_q | ({24'd0, data_byte} << shamt);
		hdr_done = !long_hdr || (hdr_cnt_q == 2'd3);
		if (cfg.mode == MODE_ABRIDGED) begin
			if (long_hdr) begin
				payload = {6'd0, accum_nx[31:8], 2'b00};
			end else begin
				payload = {23'd0, accum_nx[6:0], 2'b00};
			end
		end else begin
			payload = {1'b0, accum_nx[30:0]};
		end
		total_hdr = {1'b0, payload} + (long_hdr ? 33'd4 : 33'd1);
		bad_len = (payload == 32'd0) || (payload > {6'd0, cfg.max_payload})
			|| ((total_hdr >> LEN_WIDTH) != 33'd0);
		pos_inc = pos_q + {{(LEN_WIDTH-1){1'b0}}, 1'b1};
		pos_last = (pos_inc == frame_len_q);
		flen_ext = 33'(frame_len_q);
	end

	// result tags for the current byte
	always_comb begin
		res.byte_out = data_byte;
		res.is_header = 1'b0;
		res.frame_last = 1'b0;
		res.length_valid = 1'b0;
		res.frame_total = '0;
		res.length_error = (phase_q == PH_ERROR);
		if (cfg.enable) begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					res.length_valid = 1'b1;
					res.frame_total = flen_ext[TOTAL_W-1:0];
					res.frame_last = pos_last;
				end
				PH_ERROR: begin
					res.length_error = 1'b1;
				end
				default: begin
					res.is_header = 1'b1;
					if (hdr_done) begin
						if (bad_len) begin
							res.length_error = 1'b1;
						end else begin
							res.length_valid = 1'b1;
							res.frame_total = total_hdr[TOTAL_W-1:0];
						end
					end
				end
			endcase
		end
	end

	// frame state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_cnt_q <= 2'd0;
			hdr_long_q <= 1'b0;
			accum_q <= '0;
			frame_len_q <= '0;
			pos_q <= '0;
		end else if (step && cfg.enable) begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					pos_q <= pos_inc;
					if (pos_last) begin
						phase_q <= PH_HEADER;
						hdr_cnt_q <= 2'd0;
						hdr_long_q <= 1'b0;
						accum_q <= '0;
						frame_len_q <= '0;
						pos_q <= '0;
					end
				end
				PH_ERROR: ;
				default: begin
					hdr_long_q <= long_hdr;
					accum_q <= accum_nx;
					if (hdr_done) begin
						hdr_cnt_q <= 2'd0;
						if (bad_len) begin
							phase_q <= PH_ERROR;
							hdr_long_q <= 1'b0;
							accum_q <= '0;
							frame_len_q <= '0;
							pos_q <= '0;
						end else begin
							phase_q <= PH_PAYLOAD;
							frame_len_q <= total_hdr[LEN_WIDTH-1:0];
							pos_q <= long_hdr ? LEN_WIDTH'(4) : LEN_WIDTH'(1);
						end
					end else begin
						hdr_cnt_q <= hdr_cnt_q + 2'd1;
					end
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/length_prefixed_deframer_unit.sv -----
// length_prefixed_deframer_unit: top level of the length-prefixed deframer
// input register, parser and output register with valid/ready channels
// depends on lpd_pkg, lpd_if, lpd_regs, lpd_parse
//
// Usage: stream bytes arrive on din (valid/ready); every accepted byte yields
// exactly one tagged byte on dout, in order. Framing is chosen through the APB
// registers enable (0), mode (4) and max_payload (8); write them only while
// the block is idle. pready is always high, writes take effect on the access
// cycle.
// Path: an accepted byte sits in the input register, is decoded by the parser
// and lands in the output register, from which it leaves on dout.
// Throughput: one byte per cycle while dout is ready; the header accumulator
// and the frame byte counter update at most once for each byte that advances.
// Stalls: dout holds its transaction while ready is low; din stays ready as
// long as the output register will be emptied or already is, so one byte
// can wait in the input register behind a stalled output.
// Reset: arst_n clears the registers to enable 0, mode abridged, max_payload
// 10485760, the frame state to header phase and both stage registers to empty.
// A length error is sticky until reset.

module length_prefixed_deframer_unit import lpd_pkg::*; #(
	parameter int LEN_WIDTH = 27
) (
	input logic clk,
	input logic arst_n,
	lpd_in_if.sink din,
	lpd_out_if.source dout,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg;
	result_t res;
	result_t res_s2;
	logic valid_s1;
	logic valid_s2;
	logic [7:0] byte_s1;
	logic advance;

	lpd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	lpd_parse #(.LEN_WIDTH(LEN_WIDTH)) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(advance),
		.data_byte(byte_s1),
		.res(res)
	);

	// stage handshake
	assign advance = valid_s1 && (!valid_s2 || dout.ready);
	assign din.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.data_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (dout.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign dout.valid = valid_s2;
	assign dout.byte_out = res_s2.byte_out;
	assign dout.is_header = res_s2.is_header;
	assign dout.frame_last = res_s2.frame_last;
	assign dout.length_valid = res_s2.length_valid;
	assign dout.frame_total = res_s2.frame_total;
	assign dout.length_error = res_s2.length_error;

`ifndef SYNTH
	// a waiting input byte is neither lost nor changed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost or changed a waiting byte");

	// a stalled result is neither dropped nor changed
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !dout.ready |=> valid_s2 && $stable(res_s2))
		else $error("output stage dropped or changed a stalled result");

	// the last byte of a frame is a payload byte with a known length
	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_last |-> res_s2.length_valid && !res_s2.is_header
			&& !res_s2.length_error)
		else $error("frame_last on a byte outside a decoded payload");

	// an error result never carries a frame length
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.length_error |-> !res_s2.length_valid
			&& res_s2.frame_total == '0)
		else $error("length error together with a frame length");
`endif

endmodule
